// ===== rtl/sa_fl_pkg.sv =====
// shared types and constants of the slot allocator with a doubly linked free list
// no dependencies
package sa_fl_pkg;

    localparam int SLOT_COUNT = 1024;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int LINK_W     = SLOT_W + 1;

    // a link equal to the slot count means no slot
    localparam logic [LINK_W-1:0] NO_SLOT = LINK_W'(SLOT_COUNT);

    typedef enum logic [1:0] {
        OP_CREATE  = 2'd0,
        OP_DESTROY = 2'd1,
        OP_CLAIM   = 2'd2,
        OP_QUERY   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_USED = 2'd2,
        ST_IN_USE   = 2'd3
    } status_t;

    // one table entry: in-use bit and the free list links
    typedef struct packed {
        logic              used;
        logic [LINK_W-1:0] next;
        logic [LINK_W-1:0] prev;
    } entry_t;

endpackage

// ===== rtl/slot_allocator_free_list.sv =====
// slot allocator top level: sequencer around one synchronous entry table
// depends on sa_fl_pkg
//
// Usage
//   A request (opcode, slot_index) transfers at a rising edge where start is
//   high and busy is low. Exactly one result (result_slot, status, in_use)
//   follows, shown for one cycle with done high; the receiver cannot stall it.
//   One request is in flight at a time; busy stays high until the result is
//   set up, and a new request may start in the cycle done is shown.
// Steps per request, after the transfer edge
//   create of a fresh slot, full table, out-of-range destroy or query: idle only
//   query, failed destroy or claim of a used slot: table read, then S_LOOK
//   destroy or create from the free list: S_LOOK, maybe S_FIX_NX; claim: S_LOOK, S_FIX_NX, S_FIX_PV as needed
//   claim that grows the table pushes each new slot in S_GROW and S_FIX_NX (S_GROW
//   alone for the first slot of an empty list), then reads the slot in S_RD
// The rate is set by the single read port of the entry table: each link
// update is a read followed in the next state by a write back.
// Reset clears the free list head and the high-water mark; the table needs no
// clearing pass since slots at or above the high-water mark read as unused.
module slot_allocator_free_list
    import sa_fl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        opcode,
    input  logic [SLOT_W-1:0] slot_index,
    output logic              done,
    output logic [SLOT_W-1:0] result_slot,
    output logic [1:0]        status,
    output logic              in_use
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_GROW   = 6'b000010,
        S_RD     = 6'b000100,
        S_LOOK   = 6'b001000,
        S_FIX_NX = 6'b010000,
        S_FIX_PV = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    opcode_t           op_reg, op_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [SLOT_W-1:0] tgt_reg, tgt_next;
    logic [LINK_W-1:0] head_reg, head_next;
    logic [LINK_W-1:0] hw_reg, hw_next;
    logic [LINK_W-1:0] nx_reg, nx_next;
    logic [LINK_W-1:0] pv_reg, pv_next;
    logic              fix_pv_reg, fix_pv_next;
    logic              grow_reg, grow_next;
    logic              done_reg, done_next;
    logic [SLOT_W-1:0] result_slot_reg, result_slot_next;
    status_t           status_reg, status_next;
    logic              in_use_reg, in_use_next;
    entry_t            rd_data_reg;

    // entry table, one write and one read port
    entry_t            slot_mem [SLOT_COUNT];
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    entry_t            mem_wdata;
    logic              mem_re;
    logic [SLOT_W-1:0] mem_raddr;

    logic [LINK_W-1:0] in_ext;
    logic [LINK_W-1:0] idx_ext;
    logic [LINK_W-1:0] tgt_ext;
    logic [LINK_W-1:0] hw_inc;
    logic              head_valid;
    entry_t            rd_e;

    assign in_ext     = {1'b0, slot_index};
    assign idx_ext    = {1'b0, idx_reg};
    assign tgt_ext    = {1'b0, tgt_reg};
    assign hw_inc     = hw_reg + LINK_W'(1);
    assign head_valid = (head_reg != NO_SLOT);
    assign rd_e       = rd_data_reg;

    // table access
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= slot_mem[mem_raddr];
        end
    end

    // sequencer next state and table controls
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        idx_next         = idx_reg;
        tgt_next         = tgt_reg;
        head_next        = head_reg;
        hw_next          = hw_reg;
        nx_next          = nx_reg;
        pv_next          = pv_reg;
        fix_pv_next      = fix_pv_reg;
        grow_next        = grow_reg;
        done_next        = 1'b0;
        result_slot_next = result_slot_reg;
        status_next      = status_reg;
        in_use_next      = in_use_reg;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = '0;
        mem_re           = 1'b0;
        mem_raddr        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = opcode_t'(opcode);
                    idx_next = slot_index;
                    tgt_next = slot_index;
                    unique case (opcode_t'(opcode))
                        OP_CREATE:
                        begin
                            if (head_valid)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = head_reg[SLOT_W-1:0];
                                tgt_next   = head_reg[SLOT_W-1:0];
                                state_next = S_LOOK;
                            end
                            else if (hw_reg != NO_SLOT)
                            begin
                                // fresh slot at the high-water mark
                                mem_we           = 1'b1;
                                mem_waddr        = hw_reg[SLOT_W-1:0];
                                mem_wdata        = '{used: 1'b1, next: NO_SLOT, prev: NO_SLOT};
                                hw_next          = hw_inc;
                                done_next        = 1'b1;
                                result_slot_next = hw_reg[SLOT_W-1:0];
                                status_next      = ST_OK;
                                in_use_next      = 1'b1;
                            end
                            else
                            begin
                                done_next        = 1'b1;
                                result_slot_next = '0;
                                status_next      = ST_FULL;
                                in_use_next      = 1'b0;
                            end
                        end
                        OP_DESTROY:
                        begin
                            if (in_ext < hw_reg)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = slot_index;
                                state_next = S_LOOK;
                            end
                            else
                            begin
                                done_next        = 1'b1;
                                result_slot_next = slot_index;
                                status_next      = ST_NOT_USED;
                                in_use_next      = 1'b0;
                            end
                        end
                        OP_CLAIM:
                        begin
                            if (in_ext >= hw_reg)
                            begin
                                grow_next  = 1'b1;
                                state_next = S_GROW;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = slot_index;
                                state_next = S_LOOK;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (in_ext < hw_reg)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = slot_index;
                                state_next = S_LOOK;
                            end
                            else
                            begin
                                done_next        = 1'b1;
                                result_slot_next = slot_index;
                                status_next      = ST_OK;
                                in_use_next      = 1'b0;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // push the slot at the high-water mark onto the list head
            S_GROW:
            begin
                mem_we    = 1'b1;
                mem_waddr = hw_reg[SLOT_W-1:0];
                mem_wdata = '{used: 1'b0, next: head_reg, prev: NO_SLOT};
                head_next = hw_reg;
                hw_next   = hw_inc;
                if (head_valid)
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = head_reg[SLOT_W-1:0];
                    nx_next     = head_reg;
                    pv_next     = hw_reg;
                    fix_pv_next = 1'b0;
                    state_next  = S_FIX_NX;
                end
                else if (idx_ext < hw_inc)
                begin
                    grow_next  = 1'b0;
                    state_next = S_RD;
                end
            end

            // read the named slot after growth
            S_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = tgt_reg;
                state_next = S_LOOK;
            end

            // entry of the target slot is in the read register
            S_LOOK:
            begin
                if (op_reg == OP_QUERY)
                begin
                    done_next        = 1'b1;
                    result_slot_next = idx_reg;
                    status_next      = ST_OK;
                    in_use_next      = rd_e.used;
                    state_next       = S_IDLE;
                end
                else if (op_reg == OP_DESTROY)
                begin
                    if (!rd_e.used)
                    begin
                        done_next        = 1'b1;
                        result_slot_next = idx_reg;
                        status_next      = ST_NOT_USED;
                        in_use_next      = 1'b0;
                        state_next       = S_IDLE;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = tgt_reg;
                        mem_wdata = '{used: 1'b0, next: head_reg, prev: NO_SLOT};
                        head_next = tgt_ext;
                        if (head_valid)
                        begin
                            mem_re      = 1'b1;
                            mem_raddr   = head_reg[SLOT_W-1:0];
                            nx_next     = head_reg;
                            pv_next     = tgt_ext;
                            fix_pv_next = 1'b0;
                            state_next  = S_FIX_NX;
                        end
                        else
                        begin
                            done_next        = 1'b1;
                            result_slot_next = tgt_reg;
                            status_next      = ST_OK;
                            in_use_next      = 1'b0;
                            state_next       = S_IDLE;
                        end
                    end
                end
                else if (op_reg == OP_CLAIM && rd_e.used)
                begin
                    done_next        = 1'b1;
                    result_slot_next = idx_reg;
                    status_next      = ST_IN_USE;
                    in_use_next      = 1'b1;
                    state_next       = S_IDLE;
                end
                else
                begin
                    // unlink the target from the free list and mark it used
                    mem_we      = 1'b1;
                    mem_waddr   = tgt_reg;
                    mem_wdata   = '{used: 1'b1, next: rd_e.next, prev: rd_e.prev};
                    nx_next     = rd_e.next;
                    pv_next     = rd_e.prev;
                    fix_pv_next = (rd_e.prev != NO_SLOT);
                    if (head_reg == tgt_ext)
                    begin
                        head_next = rd_e.next;
                    end
                    if (rd_e.next != NO_SLOT)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = rd_e.next[SLOT_W-1:0];
                        state_next = S_FIX_NX;
                    end
                    else if (rd_e.prev != NO_SLOT)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = rd_e.prev[SLOT_W-1:0];
                        state_next = S_FIX_PV;
                    end
                    else
                    begin
                        done_next        = 1'b1;
                        result_slot_next = tgt_reg;
                        status_next      = ST_OK;
                        in_use_next      = 1'b1;
                        state_next       = S_IDLE;
                    end
                end
            end

            // write back the prev link of the following slot
            S_FIX_NX:
            begin
                mem_we    = 1'b1;
                mem_waddr = nx_reg[SLOT_W-1:0];
                mem_wdata = '{used: rd_e.used, next: rd_e.next, prev: pv_reg};
                if (grow_reg)
                begin
                    if (idx_ext >= hw_reg)
                    begin
                        state_next = S_GROW;
                    end
                    else
                    begin
                        grow_next  = 1'b0;
                        state_next = S_RD;
                    end
                end
                else if (fix_pv_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = pv_reg[SLOT_W-1:0];
                    state_next = S_FIX_PV;
                end
                else
                begin
                    done_next        = 1'b1;
                    result_slot_next = tgt_reg;
                    status_next      = ST_OK;
                    in_use_next      = (op_reg != OP_DESTROY);
                    state_next       = S_IDLE;
                end
            end

            // write back the next link of the preceding slot
            S_FIX_PV:
            begin
                mem_we           = 1'b1;
                mem_waddr        = pv_reg[SLOT_W-1:0];
                mem_wdata        = '{used: rd_e.used, next: nx_reg, prev: rd_e.prev};
                done_next        = 1'b1;
                result_slot_next = tgt_reg;
                status_next      = ST_OK;
                in_use_next      = 1'b1;
                state_next       = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= NO_SLOT;
            hw_reg    <= '0;
            grow_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            hw_reg    <= hw_next;
            grow_reg  <= grow_next;
            done_reg  <= done_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        idx_reg         <= idx_next;
        tgt_reg         <= tgt_next;
        nx_reg          <= nx_next;
        pv_reg          <= pv_next;
        fix_pv_reg      <= fix_pv_next;
        result_slot_reg <= result_slot_next;
        status_reg      <= status_next;
        in_use_reg      <= in_use_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign result_slot = result_slot_reg;
    assign status      = status_reg;
    assign in_use      = in_use_reg;

`ifndef NO_ASSERTIONS
    // a result only follows a request transfer or work in progress
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start) || $past(busy)))
        else $error("result without a request");

    // the list head is always a slot below the high-water mark
    a_head_below_hw: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg != NO_SLOT) |-> (head_reg < hw_reg))
        else $error("free list head above high-water mark");

    // the high-water mark never passes the table size
    a_hw_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hw_reg <= LINK_W'(SLOT_COUNT))
        else $error("high-water mark out of range");

    // a full report never marks a slot in use
    a_full_unused: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> !in_use)
        else $error("full result with in_use set");
`endif

endmodule
